### rtl/pwat_pkg.sv
package pwat_pkg;

  localparam int MaxWindows = 16;
  localparam int MaxReservations = 64;
  localparam int WinIdxW = $clog2(MaxWindows);
  localparam int WinCntW = $clog2(MaxWindows + 1);
  localparam int ResIdxW = $clog2(MaxReservations);
  localparam int ResCntW = $clog2(MaxReservations + 1);
  localparam int CfgW = 7;

  localparam logic [63:0] IoFloor = 64'h1000;
  localparam logic [63:0] Low4gTop = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_RESERVE = 2'd1,
    ACT_ALLOCATE = 2'd2,
    ACT_TRANSLATE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_INVALID = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  localparam logic [1:0] SpaceIo = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FIND_RD,
    S_FIND_CHK,
    S_RESV_REC,
    S_XLATE,
    S_AL_CHK,
    S_AL_WIN_RD,
    S_AL_WIN_INIT,
    S_AL_ALIGN,
    S_AL_RES_RD,
    S_AL_RES_CHK,
    S_AL_COMMIT,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_LOAD,
    CMD_WIN_RD,
    CMD_WIN_NEXT,
    CMD_RESV_REC,
    CMD_XLATE,
    CMD_AL_CHK,
    CMD_AL_INIT,
    CMD_AL_ALIGN,
    CMD_RES_RD,
    CMD_RES_NEXT,
    CMD_RES_HIT,
    CMD_AL_COMMIT,
    CMD_FAIL
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    status_e fail_status;
  } ctrl_t;

  typedef struct packed {
    action_e new_action;
    action_e action;
    logic win_done;
    logic win_holds;
    logic win_skip;
    logic al_invalid;
    logic align_fail;
    logic res_done;
    logic res_hit;
    logic res_full;
    logic load_bad_space;
    logic load_full;
    logic load_invalid;
  } stat_t;

endpackage

### rtl/pwat_if.sv
interface pwat_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [1:0] window_space;
  logic is_io;
  logic is_64_capable;
  logic [63:0] bus_addr;
  logic [63:0] region_size;
  logic [63:0] window_host_base;
  modport source(output valid, action, window_space, is_io, is_64_capable, bus_addr,
                 region_size, window_host_base, input ready);
  modport sink(input valid, action, window_space, is_io, is_64_capable, bus_addr,
               region_size, window_host_base, output ready);
endinterface

interface pwat_out_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [63:0] result_address;
  logic [3:0] window_index;
  modport source(output valid, status, result_address, window_index, input ready);
  modport sink(input valid, status, result_address, window_index, output ready);
endinterface

interface pwat_cfg_if;
  logic valid;
  logic ready;
  logic [6:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/pwat_ctrl.sv
module pwat_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_fire_i,
  input  pwat_pkg::stat_t stat_i,
  output pwat_pkg::ctrl_t ctrl_o,
  output logic            busy_o,
  output logic            done_o
);
  import pwat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          case (stat_i.new_action)
            ACT_LOAD: state_d = S_LOAD;
            ACT_ALLOCATE: state_d = S_AL_CHK;
            default: state_d = S_FIND_RD;
          endcase
        end
      end
      S_LOAD: state_d = S_DONE;
      S_FIND_RD: state_d = stat_i.win_done ? S_DONE : S_FIND_CHK;
      S_FIND_CHK: begin
        if (stat_i.win_holds) begin
          state_d = (stat_i.action == ACT_RESERVE) ? S_RESV_REC : S_XLATE;
        end else begin
          state_d = S_FIND_RD;
        end
      end
      S_RESV_REC: state_d = S_DONE;
      S_XLATE: state_d = S_DONE;
      S_AL_CHK: state_d = stat_i.al_invalid ? S_DONE : S_AL_WIN_RD;
      S_AL_WIN_RD: state_d = stat_i.win_done ? S_DONE : S_AL_WIN_INIT;
      S_AL_WIN_INIT: state_d = stat_i.win_skip ? S_AL_WIN_RD : S_AL_ALIGN;
      S_AL_ALIGN: state_d = stat_i.align_fail ? S_AL_WIN_RD : S_AL_RES_RD;
      S_AL_RES_RD: state_d = stat_i.res_done ? S_AL_COMMIT : S_AL_RES_CHK;
      S_AL_RES_CHK: state_d = stat_i.res_hit ? S_AL_ALIGN : S_AL_RES_RD;
      S_AL_COMMIT: state_d = S_DONE;
      S_DONE: if (out_fire_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.cmd = CMD_NONE;
    ctrl_o.fail_status = ST_OK;
    case (state_q)
      S_IDLE: if (in_fire_i) ctrl_o.cmd = CMD_START;
      S_LOAD: ctrl_o.cmd = CMD_LOAD;
      S_FIND_RD: begin
        if (stat_i.win_done) begin
          ctrl_o.cmd = CMD_FAIL;
          ctrl_o.fail_status = ST_NOT_FOUND;
        end else begin
          ctrl_o.cmd = CMD_WIN_RD;
        end
      end
      S_FIND_CHK: if (!stat_i.win_holds) ctrl_o.cmd = CMD_WIN_NEXT;
      S_RESV_REC: ctrl_o.cmd = CMD_RESV_REC;
      S_XLATE: ctrl_o.cmd = CMD_XLATE;
      S_AL_CHK: ctrl_o.cmd = CMD_AL_CHK;
      S_AL_WIN_RD: begin
        if (stat_i.win_done) begin
          ctrl_o.cmd = CMD_FAIL;
          ctrl_o.fail_status = ST_NO_SPACE;
        end else begin
          ctrl_o.cmd = CMD_WIN_RD;
        end
      end
      S_AL_WIN_INIT: ctrl_o.cmd = stat_i.win_skip ? CMD_WIN_NEXT : CMD_AL_INIT;
      S_AL_ALIGN: ctrl_o.cmd = stat_i.align_fail ? CMD_WIN_NEXT : CMD_AL_ALIGN;
      S_AL_RES_RD: if (!stat_i.res_done) ctrl_o.cmd = CMD_RES_RD;
      S_AL_RES_CHK: ctrl_o.cmd = stat_i.res_hit ? CMD_RES_HIT : CMD_RES_NEXT;
      S_AL_COMMIT: ctrl_o.cmd = CMD_AL_COMMIT;
      default: ctrl_o.cmd = CMD_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

### rtl/pwat_dp.sv
module pwat_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pwat_pkg::ctrl_t        ctrl_i,
  output pwat_pkg::stat_t        stat_o,
  input  logic [1:0]             action_i,
  input  logic [1:0]             window_space_i,
  input  logic                   is_io_i,
  input  logic                   is_64_capable_i,
  input  logic [63:0]            bus_addr_i,
  input  logic [63:0]            region_size_i,
  input  logic [63:0]            window_host_base_i,
  input  logic                   cfg_we_i,
  input  logic [pwat_pkg::CfgW-1:0] cfg_data_i,
  output logic [2:0]             status_o,
  output logic [63:0]            result_address_o,
  output logic [3:0]             window_index_o
);
  import pwat_pkg::*;

  // Window table lives in five memories: spaces, bus bases, host bases, sizes, and cursors.
  logic [1:0]  wsp_mem [MaxWindows];
  logic [63:0] wbase_mem [MaxWindows];
  logic [63:0] whost_mem [MaxWindows];
  logic [63:0] wsize_mem [MaxWindows];
  logic [63:0] wcur_mem [MaxWindows];
  logic [WinIdxW-1:0] rwin_mem [MaxReservations];
  logic [63:0] rstart_mem [MaxReservations];
  logic [63:0] rend_mem [MaxReservations];

  logic [CfgW-1:0] limit_q;
  logic [WinCntW-1:0] win_count_q;
  logic [ResCntW-1:0] res_count_q;

  action_e act_q;
  logic [1:0] space_q;
  logic io_q, wide_q;
  logic [63:0] bus_q, size_q, host_q;

  logic [WinCntW-1:0] wi_q;
  logic [ResCntW-1:0] ri_q;
  logic [1:0] rd_sp_q;
  logic [63:0] rd_base_q, rd_host_q, rd_size_q, rd_cur_q;
  logic [WinIdxW-1:0] rd_rwin_q;
  logic [63:0] rd_rstart_q, rd_rend_q;
  logic [63:0] cand_q, mask_q;
  logic [2:0] status_q;
  logic [63:0] addr_q;
  logic [3:0] widx_q;

  logic [63:0] off, al_sum, al_cand, al_off, next_addr;
  logic io_match, holds, res_full, al_fail;
  logic [ResCntW-1:0] lim_eff;
  logic [WinIdxW-1:0] wi;
  logic [ResIdxW-1:0] ri;
  logic [64:0] host_sum;

  assign wi = wi_q[WinIdxW-1:0];
  assign ri = ri_q[ResIdxW-1:0];

  assign io_match = (io_q == (rd_sp_q == SpaceIo));
  assign off = bus_q - rd_base_q;
  assign holds = (size_q != 64'd0) && io_match && (bus_q >= rd_base_q) &&
                 (off < rd_size_q) && (size_q <= rd_size_q - off);

  always_comb begin
    if (ResCntW'(limit_q) > ResCntW'(MaxReservations)) begin
      lim_eff = ResCntW'(MaxReservations);
    end else begin
      lim_eff = ResCntW'(limit_q);
    end
  end
  assign res_full = (res_count_q >= lim_eff);

  assign al_sum = cand_q + mask_q;
  assign al_cand = al_sum & ~mask_q;
  assign al_off = al_cand - rd_base_q;
  assign al_fail = (cand_q > ~mask_q) || (al_cand < rd_base_q) ||
                   (al_off >= rd_size_q) || (size_q > rd_size_q - al_off) ||
                   (!wide_q && ((al_cand > Low4gTop) || (mask_q > Low4gTop - al_cand)));
  assign next_addr = cand_q + size_q;
  assign host_sum = {1'b0, rd_host_q} + {1'b0, off};

  always_comb begin
    stat_o.new_action = action_e'(action_i);
    stat_o.action = act_q;
    stat_o.win_done = (wi_q >= win_count_q);
    stat_o.win_holds = holds;
    stat_o.win_skip = (io_q != (rd_sp_q == SpaceIo)) || (!wide_q && rd_base_q > Low4gTop);
    stat_o.al_invalid = (size_q == 64'd0) || ((size_q & (size_q - 64'd1)) != 64'd0);
    stat_o.align_fail = al_fail;
    stat_o.res_done = (ri_q >= res_count_q);
    stat_o.res_hit = (rd_rwin_q == wi) && (cand_q < rd_rend_q) && (rd_rstart_q < next_addr);
    stat_o.res_full = res_full;
    stat_o.load_bad_space = (space_q == 2'd0);
    stat_o.load_full = (win_count_q >= WinCntW'(MaxWindows));
    stat_o.load_invalid = (size_q == 64'd0) || (bus_q > ~size_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CfgW'(64);
      win_count_q <= '0;
      res_count_q <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      case (ctrl_i.cmd)
        CMD_LOAD: begin
          if (!stat_o.load_bad_space && !stat_o.load_full && !stat_o.load_invalid) begin
            win_count_q <= win_count_q + 1'b1;
          end
        end
        CMD_RESV_REC, CMD_AL_COMMIT: if (!res_full) res_count_q <= res_count_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Table writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_LOAD && !stat_o.load_bad_space && !stat_o.load_full &&
        !stat_o.load_invalid) begin
      wsp_mem[win_count_q[WinIdxW-1:0]] <= space_q;
      wbase_mem[win_count_q[WinIdxW-1:0]] <= bus_q;
      whost_mem[win_count_q[WinIdxW-1:0]] <= host_q;
      wsize_mem[win_count_q[WinIdxW-1:0]] <= size_q;
      wcur_mem[win_count_q[WinIdxW-1:0]] <= bus_q;
    end
    if (ctrl_i.cmd == CMD_AL_COMMIT && !res_full) begin
      wcur_mem[wi] <= next_addr;
    end
    if ((ctrl_i.cmd == CMD_RESV_REC || ctrl_i.cmd == CMD_AL_COMMIT) && !res_full) begin
      rwin_mem[res_count_q[ResIdxW-1:0]] <= wi;
      rstart_mem[res_count_q[ResIdxW-1:0]] <= (ctrl_i.cmd == CMD_RESV_REC) ? bus_q : cand_q;
      rend_mem[res_count_q[ResIdxW-1:0]] <= (ctrl_i.cmd == CMD_RESV_REC) ?
                                            bus_q + size_q : next_addr;
    end
    if (ctrl_i.cmd == CMD_WIN_RD) begin
      rd_sp_q <= wsp_mem[wi];
      rd_base_q <= wbase_mem[wi];
      rd_host_q <= whost_mem[wi];
      rd_size_q <= wsize_mem[wi];
      rd_cur_q <= wcur_mem[wi];
    end
    if (ctrl_i.cmd == CMD_RES_RD) begin
      rd_rwin_q <= rwin_mem[ri];
      rd_rstart_q <= rstart_mem[ri];
      rd_rend_q <= rend_mem[ri];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_START: begin
        act_q <= action_e'(action_i);
        space_q <= window_space_i;
        io_q <= is_io_i;
        wide_q <= is_64_capable_i;
        bus_q <= bus_addr_i;
        size_q <= region_size_i;
        host_q <= window_host_base_i;
        wi_q <= '0;
        status_q <= ST_OK;
        addr_q <= '0;
        widx_q <= '0;
      end
      CMD_LOAD: begin
        if (stat_o.load_bad_space) status_q <= ST_IGNORED;
        else if (stat_o.load_full) status_q <= ST_NO_SPACE;
        else if (stat_o.load_invalid) status_q <= ST_INVALID;
        else widx_q <= 4'(win_count_q);
      end
      CMD_WIN_NEXT: wi_q <= wi_q + 1'b1;
      CMD_RESV_REC: begin
        if (res_full) status_q <= ST_NO_SPACE;
        else widx_q <= 4'(wi_q);
      end
      CMD_XLATE: begin
        if (host_sum[64]) begin
          status_q <= ST_INVALID;
        end else begin
          addr_q <= host_sum[63:0];
          widx_q <= 4'(wi_q);
        end
      end
      CMD_AL_CHK: begin
        mask_q <= size_q - 64'd1;
        if (stat_o.al_invalid) status_q <= ST_INVALID;
      end
      CMD_AL_INIT: begin
        if (io_q && rd_cur_q < IoFloor && rd_base_q <= IoFloor) cand_q <= IoFloor;
        else cand_q <= rd_cur_q;
      end
      CMD_AL_ALIGN: begin
        cand_q <= al_cand;
        ri_q <= '0;
      end
      CMD_RES_NEXT: ri_q <= ri_q + 1'b1;
      CMD_RES_HIT: cand_q <= rd_rend_q;
      CMD_AL_COMMIT: begin
        if (res_full) begin
          status_q <= ST_NO_SPACE;
        end else begin
          addr_q <= cand_q;
          widx_q <= 4'(wi_q);
        end
      end
      CMD_FAIL: status_q <= ctrl_i.fail_status;
      default: ;
    endcase
  end

  assign status_o = status_q;
  assign result_address_o = addr_q;
  assign window_index_o = widx_q;

endmodule

### rtl/pci_window_allocate_translate.sv
// Load writes one window entry; reserve and translate scan the windows in order;
// allocate scans the windows and compares each cursor step with the recorded reservations.
// Throughput: one item at a time; the next is taken after the result beat leaves.
// The window and reservation scans are walks over one-read-port tables.
// Reset clears the counts, the controller and the limit (to 64); tables are not cleared.
module pci_window_allocate_translate (
  input logic    clk_i,
  input logic    rst_ni,
  pwat_in_if.sink   in_ch,
  pwat_out_if.source out_ch,
  pwat_cfg_if.sink  cfg_ch
);
  import pwat_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic busy, done, in_fire, out_fire;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && !busy;
  assign out_ch.valid = done;
  assign out_fire = done && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  pwat_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire),
    .out_fire_i(out_fire),
    .stat_i(stat),
    .ctrl_o(ctrl),
    .busy_o(busy),
    .done_o(done)
  );

  pwat_dp u_dp (
    .clk_i, .rst_ni,
    .ctrl_i(ctrl),
    .stat_o(stat),
    .action_i(in_ch.action),
    .window_space_i(in_ch.window_space),
    .is_io_i(in_ch.is_io),
    .is_64_capable_i(in_ch.is_64_capable),
    .bus_addr_i(in_ch.bus_addr),
    .region_size_i(in_ch.region_size),
    .window_host_base_i(in_ch.window_host_base),
    .cfg_we_i(cfg_ch.valid),
    .cfg_data_i(cfg_ch.data),
    .status_o(out_ch.status),
    .result_address_o(out_ch.result_address),
    .window_index_o(out_ch.window_index)
  );

endmodule

### test/tb_pkg.sv
package tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import pwat_pkg::*;

  typedef struct packed {
    action_e     action;
    logic [1:0]  window_space;
    logic        is_io;
    logic        is_64_capable;
    logic [63:0] bus_addr;
    logic [63:0] region_size;
    logic [63:0] window_host_base;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] result_address;
    logic [3:0]  window_index;
  } answer_t;
endpackage

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pwat_pkg::*;
  import tb_pkg::*;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  pwat_in_if  in_ch();
  pwat_out_if out_ch();
  pwat_cfg_if cfg_ch();

  pci_window_allocate_translate i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Shadow copy of the bridge state.
  logic [1:0]  sh_space [MaxWindows];
  logic [63:0] sh_base  [MaxWindows];
  logic [63:0] sh_host  [MaxWindows];
  logic [63:0] sh_size  [MaxWindows];
  logic [63:0] sh_cursor[MaxWindows];
  int          sh_wins;
  int          sh_resv_win [MaxReservations];
  logic [63:0] sh_resv_start[MaxReservations];
  logic [63:0] sh_resv_size [MaxReservations];
  int          sh_resvs;
  int          sh_limit;

  answer_t answers_due[$];
  int      errors = 0;
  int      answers_seen = 0;
  bit      hold_off = 0;

  function automatic bit holds(int w, bit io, logic [63:0] a, logic [63:0] s);
    logic [63:0] off;
    if (s == 0 || io != (sh_space[w] == SpaceIo) || a < sh_base[w]) return 0;
    off = a - sh_base[w];
    return off < sh_size[w] && s <= sh_size[w] - off;
  endfunction

  function automatic int lookup_window(bit io, logic [63:0] a, logic [63:0] s);
    for (int i = 0; i < sh_wins; i++) if (holds(i, io, a, s)) return i;
    return -1;
  endfunction

  function automatic bit note_reservation(int w, logic [63:0] a, logic [63:0] s);
    int lim;
    lim = sh_limit > MaxReservations ? MaxReservations : sh_limit;
    if (sh_resvs >= lim) return 0;
    sh_resv_win[sh_resvs] = w;
    sh_resv_start[sh_resvs] = a;
    sh_resv_size[sh_resvs] = s;
    sh_resvs++;
    return 1;
  endfunction

  function automatic answer_t place_bar(request_t q);
    answer_t     ans;
    logic [63:0] mask, base, cand, nxt, rend, s;
    bit          io, wide, hit;
    ans = '{ST_NO_SPACE, 64'd0, 4'd0};
    s = q.region_size;
    io = q.is_io;
    wide = q.is_64_capable;
    if (s == 0 || (s & (s - 1)) != 0) begin
      ans.status = ST_INVALID;
      return ans;
    end
    mask = s - 1;
    for (int i = 0; i < sh_wins; i++) begin
      base = sh_base[i];
      cand = sh_cursor[i];
      if (io != (sh_space[i] == SpaceIo)) continue;
      if (!wide && base > Low4gTop) continue;
      if (io && cand < IoFloor && base <= IoFloor) cand = IoFloor;
      forever begin
        hit = 0;
        if (cand > AllOnes - mask) break;
        cand = (cand + mask) & ~mask;
        if (cand < base || cand - base >= sh_size[i] || s > sh_size[i] - (cand - base)) break;
        if (!wide && (cand > Low4gTop || mask > Low4gTop - cand)) break;
        nxt = cand + s;
        for (int r = 0; r < sh_resvs; r++) begin
          if (sh_resv_win[r] != i) continue;
          rend = sh_resv_start[r] + sh_resv_size[r];
          if (cand < rend && sh_resv_start[r] < nxt) begin
            cand = rend;
            hit = 1;
            break;
          end
        end
        if (hit) continue;
        if (!note_reservation(i, cand, s)) return ans;
        sh_cursor[i] = nxt;
        ans = '{ST_OK, cand, 4'(i)};
        return ans;
      end
    end
    return ans;
  endfunction

  function automatic answer_t bridge_answer(request_t q);
    answer_t     ans;
    int          w;
    logic [63:0] off;
    ans = '{ST_OK, 64'd0, 4'd0};
    case (q.action)
      ACT_LOAD: begin
        if (q.window_space == 0) ans.status = ST_IGNORED;
        else if (sh_wins >= MaxWindows) ans.status = ST_NO_SPACE;
        else if (q.region_size == 0 || q.bus_addr > AllOnes - q.region_size)
          ans.status = ST_INVALID;
        else begin
          ans.window_index = 4'(sh_wins);
          sh_space[sh_wins] = q.window_space;
          sh_base[sh_wins] = q.bus_addr;
          sh_host[sh_wins] = q.window_host_base;
          sh_size[sh_wins] = q.region_size;
          sh_cursor[sh_wins] = q.bus_addr;
          sh_wins++;
        end
      end
      ACT_RESERVE: begin
        w = lookup_window(q.is_io, q.bus_addr, q.region_size);
        if (w < 0) ans.status = ST_NOT_FOUND;
        else if (!note_reservation(w, q.bus_addr, q.region_size)) ans.status = ST_NO_SPACE;
        else ans.window_index = 4'(w);
      end
      ACT_ALLOCATE: ans = place_bar(q);
      default: begin
        w = lookup_window(q.is_io, q.bus_addr, q.region_size);
        if (w < 0) ans.status = ST_NOT_FOUND;
        else begin
          off = q.bus_addr - sh_base[w];
          if (sh_host[w] > AllOnes - off) ans.status = ST_INVALID;
          else ans = '{ST_OK, sh_host[w] + off, 4'(w)};
        end
      end
    endcase
    return ans;
  endfunction

  // Sender: bursts with random gaps. Valid stays high inside a burst and drops
  // only when a gap starts or the sender waits for results.
  int burst_left = 0;

  task automatic send_request(request_t q);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.action <= q.action;
    in_ch.window_space <= q.window_space;
    in_ch.is_io <= q.is_io;
    in_ch.is_64_capable <= q.is_64_capable;
    in_ch.bus_addr <= q.bus_addr;
    in_ch.region_size <= q.region_size;
    in_ch.window_host_base <= q.window_host_base;
    answers_due.push_back(bridge_answer(q));
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    // No scan is still running once the last answer is out; the wait below is extra margin.
    while (guard < 400) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic write_limit(int value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= 7'(value);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sh_limit = value;
  endtask

  function automatic request_t make_req(action_e a, logic [1:0] sp, bit io, bit wide,
                                        logic [63:0] bus, logic [63:0] sz,
                                        logic [63:0] host);
    request_t q;
    q = '{a, sp, io, wide, bus, sz, host};
    return q;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pow2(int lo, int hi);
    return 64'd1 << $urandom_range(lo, hi);
  endfunction

  task automatic test_directed();
    send_request(make_req(ACT_LOAD, 2'd0, 0, 0, 64'h1000, 64'h1000, 0));
    send_request(make_req(ACT_LOAD, 2'd2, 0, 0, 64'h8000_0000, 0, 0));
    send_request(make_req(ACT_LOAD, 2'd3, 0, 0, AllOnes, 64'd2, 0));
    send_request(make_req(ACT_LOAD, 2'd1, 1, 0, 64'h0, 64'h1_0000, 64'h3eff_0000_0000));
    send_request(make_req(ACT_LOAD, 2'd2, 0, 0, 64'h8000_0000, 64'h4000_0000,
                          64'h4000_8000_0000));
    send_request(make_req(ACT_LOAD, 2'd3, 0, 1, 64'h10_0000_0000, 64'h10_0000_0000,
                          AllOnes - 64'h100));
    send_request(make_req(ACT_LOAD, 2'd2, 0, 0, 64'hFFFF_0000, 64'h2_0000, 64'h0));
    send_request(make_req(ACT_ALLOCATE, 0, 1, 0, 0, 64'h100, 0));
    send_request(make_req(ACT_ALLOCATE, 0, 0, 0, 0, 64'd3, 0));
    send_request(make_req(ACT_ALLOCATE, 0, 0, 0, 0, 64'd0, 0));
    send_request(make_req(ACT_RESERVE, 0, 0, 0, 64'h8000_0000, 64'h1000, 0));
    send_request(make_req(ACT_RESERVE, 0, 1, 0, 64'h8000_0000, 64'h1000, 0));
    send_request(make_req(ACT_RESERVE, 0, 0, 0, 64'h8000_0000, 64'h0, 0));
    send_request(make_req(ACT_ALLOCATE, 0, 0, 0, 0, 64'h1000, 0));
    send_request(make_req(ACT_ALLOCATE, 0, 0, 0, 0, 64'h8000_0000, 0));
    send_request(make_req(ACT_ALLOCATE, 0, 0, 1, 0, 64'h8_0000_0000, 0));
    send_request(make_req(ACT_ALLOCATE, 0, 0, 1, 0, 64'h8000_0000_0000_0000, 0));
    send_request(make_req(ACT_TRANSLATE, 0, 1, 0, 64'h10, 64'h10, 0));
    send_request(make_req(ACT_TRANSLATE, 0, 0, 0, 64'h10_0000_0200, 64'h10, 0));
    send_request(make_req(ACT_TRANSLATE, 0, 0, 0, 64'h5, 64'h1, 0));
    send_request(make_req(ACT_TRANSLATE, 0, 0, 0, 64'h8000_0000, AllOnes, 0));
  endtask

  task automatic test_window_table_full();
    for (int i = 0; i < MaxWindows + 2; i++)
      send_request(make_req(ACT_LOAD, 2'($urandom_range(1, 3)), 0, 0,
                            64'(i) << 32, 64'h1000_0000, rand64()));
  endtask

  function automatic request_t random_req();
    request_t    q;
    int          w;
    logic [63:0] off;
    q = '{action_e'($urandom_range(0, 3)), 2'($urandom()), 1'($urandom()),
          1'($urandom()), rand64(), rand64(), rand64()};
    if ($urandom_range(0, 9) == 0) return q;
    w = sh_wins == 0 ? -1 : $urandom_range(0, sh_wins - 1);
    case (q.action)
      ACT_LOAD: begin
        q.window_space = 2'($urandom_range(1, 3));
        q.is_io = q.window_space == SpaceIo;
        case ($urandom_range(0, 2))
          0: q.bus_addr = 64'($urandom_range(0, 15)) << 12;
          1: q.bus_addr = {32'd0, $urandom()} & ~64'hFFFF;
          default: q.bus_addr = rand64() & ~64'hF_FFFF_FFFF;
        endcase
        q.region_size = $urandom_range(0, 3) == 0 ? rand64() : pow2(8, 28);
      end
      ACT_ALLOCATE: begin
        q.region_size = $urandom_range(0, 12) == 0 ? rand64() : pow2(0, 24);
        if (w >= 0 && $urandom_range(0, 1)) q.is_io = sh_space[w] == SpaceIo;
      end
      default: begin
        if (w >= 0 && $urandom_range(0, 5) != 0) begin
          q.is_io = sh_space[w] == SpaceIo;
          off = rand64() % sh_size[w];
          q.bus_addr = sh_base[w] + off;
          q.region_size = 64'($urandom_range(1, 4096)) % (sh_size[w] - off + 1);
        end
      end
    endcase
    return q;
  endfunction

  task automatic test_random(int n, int limit);
    write_limit(limit);
    for (int i = 0; i < n; i++) send_request(random_req());
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 6; i++) send_request(random_req());
    drain();
    wait (!hold_off);
  endtask

  // Receiver with its own stall pattern, plus a long hold-off when asked.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      n = $urandom_range(0, 7);
      out_ch.ready <= n < 5 || $urandom_range(0, 1);
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{status_e'(out_ch.status), out_ch.result_address, out_ch.window_index};
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = answers_due.pop_front();
        answers_seen++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: expected %p got %p", answers_seen, want, got);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.window_space = '0;
    in_ch.is_io = 1'b0;
    in_ch.is_64_capable = 1'b0;
    in_ch.bus_addr = '0;
    in_ch.region_size = '0;
    in_ch.window_host_base = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    sh_wins = 0;
    sh_resvs = 0;
    sh_limit = 64;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(150, 127);
    test_window_table_full();
    test_random(150, 0);
    test_random(150, 3);
    test_random(150, 64);
    drain();
    if (errors == 0) $display("PASS pci_window_allocate_translate");
    else $display("FAIL pci_window_allocate_translate");
    $finish;
  end

  initial begin
    #500ms;
    $display("FAIL pci_window_allocate_translate");
    $finish;
  end
endmodule

### filelist.f
rtl/pwat_pkg.sv
rtl/pwat_if.sv
rtl/pwat_ctrl.sv
rtl/pwat_dp.sv
rtl/pci_window_allocate_translate.sv
test/tb_pkg.sv
test/tb_top.sv
